FILE: rtl/sara_pkg.sv
// Shared constants and codes for the shelf atlas region allocator.
// No dependencies; imported by the allocator core and the bench.
package sara_pkg;

	localparam int MAX_SHELVES = 32;
	localparam int SHELF_IW    = 5;
	localparam int MAX_SPANS   = 16;
	localparam int SPAN_IW     = 4;
	localparam int SIDE_MAX    = 4096;
	localparam int SPAN_DEPTH  = MAX_SHELVES * MAX_SPANS;

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_CLEAR   = 2'd2;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_ASHELF  = 11'b00000000010,
		S_ASREAD  = 11'b00000000100,
		S_ASWAIT  = 11'b00000001000,
		S_ASHREAD = 11'b00000010000,
		S_ASHWAIT = 11'b00000100000,
		S_RFIND   = 11'b00001000000,
		S_RREAD   = 11'b00010000000,
		S_RWAIT   = 11'b00100000000,
		S_RFLUSH  = 11'b01000000000,
		S_RWB     = 11'b10000000000
	} state_t;

	typedef struct packed {
		logic [11:0] start;
		logic [12:0] len;
	} span_t;

endpackage

FILE: rtl/shelf_atlas_region_allocator_core.sv
// Shelf atlas region allocator: shelf table in flops, free spans in a memory.
// Depends on sara_pkg.
//
// A command is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and the receiver cannot stall.
// A clear or a command rejected on sight shows its result in the cycle right
// after it is taken, and the block is free again in that same cycle. Other
// commands run a sequencer that walks non-matching shelves one per cycle and
// reads each free span of a matching shelf through the span memory's read
// port. The longest allocation is one with all 32 shelves matching and each
// holding 16 spans that are too short. A release finds its shelf, reads the
// shelf's spans (with one more step to slot in the new span), then writes the
// merged list back one span per cycle. No clearing pass is needed after reset.
module shelf_atlas_region_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [12:0] item_w,
	input  logic [12:0] item_h,
	input  logic [11:0] slot_x,
	input  logic [11:0] slot_y,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_wdata,
	output logic        done,
	output logic [1:0]  status,
	output logic [11:0] place_x,
	output logic [11:0] place_y,
	output logic [12:0] place_w,
	output logic [12:0] place_h
);
	import sara_pkg::*;

	state_t      st_q;
	logic [12:0] aw_cfg_q, ah_cfg_q, aw, ah;
	logic [5:0]  shelf_cnt_q;
	logic [12:0] next_top_q;
	logic [12:0] top_q [MAX_SHELVES];
	logic [12:0] hgt_q [MAX_SHELVES];
	logic [12:0] fill_q [MAX_SHELVES];
	logic [4:0]  scnt_q [MAX_SHELVES];
	logic [5:0]  s_q;
	logic [4:0]  i_q, k_q, m_q;
	logic [12:0] w_q, h_q, len_q;
	logic [11:0] x_q, y_q, px_q;
	logic        placed_q, have_q;
	span_t       cur_q;
	span_t       scr_q [MAX_SPANS + 1];
	span_t       mem_q [SPAN_DEPTH];
	span_t       rd_q;

	logic [SHELF_IW-1:0] sx;
	logic        mem_we, mem_re;
	logic [SHELF_IW+SPAN_IW-1:0] mem_waddr, mem_raddr;
	span_t       mem_wdata;
	logic        feed_en;
	span_t       fe;
	logic [13:0] cur_end;
	logic [12:0] room;
	logic [13:0] fill_sum, y_sum;

	assign aw = (aw_cfg_q > 13'(SIDE_MAX)) ? 13'(SIDE_MAX) : aw_cfg_q;
	assign ah = (ah_cfg_q > 13'(SIDE_MAX)) ? 13'(SIDE_MAX) : ah_cfg_q;
	assign sx = s_q[SHELF_IW-1:0];
	assign busy = (st_q != S_IDLE);
	assign room = 13'(SIDE_MAX) - {1'b0, slot_x};
	assign cur_end = {2'b0, cur_q.start} + {1'b0, cur_q.len};
	assign fill_sum = {1'b0, fill_q[sx]} + {1'b0, w_q};
	assign y_sum = {1'b0, next_top_q} + {1'b0, h_q};

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_waddr = {sx, i_q[SPAN_IW-1:0]};
		mem_raddr = {sx, i_q[SPAN_IW-1:0]};
		mem_wdata = rd_q;
		feed_en = 1'b0;
		fe.start = x_q;
		fe.len = len_q;
		unique case (st_q)
			S_ASREAD: mem_re = (i_q < scnt_q[sx]);
			S_ASWAIT: begin
				mem_we = (rd_q.len > w_q);
				mem_wdata.start = rd_q.start + w_q[11:0];
				mem_wdata.len = rd_q.len - w_q;
			end
			S_ASHREAD: begin
				mem_re = (k_q < scnt_q[sx]);
				mem_raddr = {sx, k_q[SPAN_IW-1:0]};
			end
			S_ASHWAIT: begin
				mem_we = 1'b1;
				mem_waddr = {sx, 4'(k_q - 5'd1)};
			end
			S_RREAD: begin
				mem_re = (i_q < scnt_q[sx]);
				feed_en = !mem_re && !placed_q;
			end
			S_RWAIT: begin
				feed_en = 1'b1;
				if (placed_q || rd_q.start <= x_q) fe = rd_q;
			end
			S_RWB: begin
				mem_we = (i_q != m_q);
				mem_wdata = scr_q[i_q];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (mem_re) rd_q <= mem_q[mem_raddr];
	end

	// Payload of the shelf table and the merge scratch list.
	always_ff @(posedge clk) begin
		if (st_q == S_ASHELF && s_q == shelf_cnt_q && !(y_sum > {1'b0, ah})
			&& shelf_cnt_q < 6'(MAX_SHELVES)) begin
			top_q[shelf_cnt_q[SHELF_IW-1:0]] <= next_top_q;
			hgt_q[shelf_cnt_q[SHELF_IW-1:0]] <= h_q;
			fill_q[shelf_cnt_q[SHELF_IW-1:0]] <= w_q;
			scnt_q[shelf_cnt_q[SHELF_IW-1:0]] <= 5'd0;
		end
		if (st_q == S_ASREAD && i_q >= scnt_q[sx] && !(fill_sum > {1'b0, aw}))
			fill_q[sx] <= fill_sum[12:0];
		if (st_q == S_ASHREAD && k_q >= scnt_q[sx])
			scnt_q[sx] <= scnt_q[sx] - 5'd1;
		if (st_q == S_RWB && i_q == m_q)
			scnt_q[sx] <= m_q;
		if (feed_en && have_q && cur_end != {2'b0, fe.start})
			scr_q[m_q] <= cur_q;
		if (st_q == S_RFLUSH)
			scr_q[m_q] <= cur_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			aw_cfg_q <= 13'd1024;
			ah_cfg_q <= 13'd1024;
			shelf_cnt_q <= '0;
			next_top_q <= '0;
			done <= 1'b0;
			status <= ST_DONE;
			place_x <= '0;
			place_y <= '0;
			place_w <= '0;
			place_h <= '0;
			s_q <= '0;
			i_q <= '0;
			k_q <= '0;
			m_q <= '0;
			w_q <= '0;
			h_q <= '0;
			len_q <= '0;
			x_q <= '0;
			y_q <= '0;
			px_q <= '0;
			placed_q <= 1'b0;
			have_q <= 1'b0;
			cur_q <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == CFG_WIDTH) aw_cfg_q <= cfg_wdata;
				if (cfg_index == CFG_HEIGHT) ah_cfg_q <= cfg_wdata;
			end
			if (feed_en) begin
				if (have_q && cur_end == {2'b0, fe.start}) begin
					cur_q.len <= cur_q.len + fe.len;
				end else begin
					if (have_q) m_q <= m_q + 5'd1;
					cur_q <= fe;
				end
				have_q <= 1'b1;
			end
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						done <= 1'b1;
						status <= ST_REJECT;
						place_x <= '0;
						place_y <= '0;
						place_w <= '0;
						place_h <= '0;
						w_q <= item_w;
						h_q <= item_h;
						x_q <= slot_x;
						y_q <= slot_y;
						len_q <= (item_w > room) ? room : item_w;
						s_q <= '0;
						priority if (action == ACT_ALLOC) begin
							if (item_w != 0 && item_h != 0 && item_w <= aw && item_h <= ah) begin
								done <= 1'b0;
								st_q <= S_ASHELF;
							end
						end else if (action == ACT_RELEASE) begin
							if (item_w != 0 && item_h != 0) begin
								done <= 1'b0;
								st_q <= S_RFIND;
							end
						end else if (action == ACT_CLEAR) begin
							shelf_cnt_q <= '0;
							next_top_q <= '0;
							status <= ST_DONE;
						end else begin
							// Unknown actions keep the reject result set above.
						end
					end
				end
				S_ASHELF: begin
					if (s_q == shelf_cnt_q) begin
						done <= 1'b1;
						st_q <= S_IDLE;
						if (y_sum > {1'b0, ah} || shelf_cnt_q >= 6'(MAX_SHELVES)) begin
							status <= ST_REJECT;
						end else begin
							status <= ST_DONE;
							place_y <= next_top_q[11:0];
							place_w <= w_q;
							place_h <= h_q;
							shelf_cnt_q <= shelf_cnt_q + 6'd1;
							next_top_q <= y_sum[12:0];
						end
					end else if (hgt_q[sx] != h_q) begin
						s_q <= s_q + 6'd1;
					end else begin
						i_q <= '0;
						st_q <= S_ASREAD;
					end
				end
				S_ASREAD: begin
					if (i_q < scnt_q[sx]) begin
						st_q <= S_ASWAIT;
					end else if (!(fill_sum > {1'b0, aw})) begin
						done <= 1'b1;
						status <= ST_DONE;
						place_x <= fill_q[sx][11:0];
						place_y <= top_q[sx][11:0];
						place_w <= w_q;
						place_h <= h_q;
						st_q <= S_IDLE;
					end else begin
						s_q <= s_q + 6'd1;
						st_q <= S_ASHELF;
					end
				end
				S_ASWAIT: begin
					if (rd_q.len < w_q) begin
						i_q <= i_q + 5'd1;
						st_q <= S_ASREAD;
					end else if (rd_q.len > w_q) begin
						done <= 1'b1;
						status <= ST_DONE;
						place_x <= rd_q.start;
						place_y <= top_q[sx][11:0];
						place_w <= w_q;
						place_h <= h_q;
						st_q <= S_IDLE;
					end else begin
						px_q <= rd_q.start;
						k_q <= i_q + 5'd1;
						st_q <= S_ASHREAD;
					end
				end
				S_ASHREAD: begin
					if (k_q < scnt_q[sx]) begin
						st_q <= S_ASHWAIT;
					end else begin
						done <= 1'b1;
						status <= ST_DONE;
						place_x <= px_q;
						place_y <= top_q[sx][11:0];
						place_w <= w_q;
						place_h <= h_q;
						st_q <= S_IDLE;
					end
				end
				S_ASHWAIT: begin
					k_q <= k_q + 5'd1;
					st_q <= S_ASHREAD;
				end
				S_RFIND: begin
					if (s_q == shelf_cnt_q) begin
						done <= 1'b1;
						status <= ST_REJECT;
						st_q <= S_IDLE;
					end else if (top_q[sx] == {1'b0, y_q} && hgt_q[sx] == h_q) begin
						i_q <= '0;
						m_q <= '0;
						placed_q <= 1'b0;
						have_q <= 1'b0;
						st_q <= S_RREAD;
					end else begin
						s_q <= s_q + 6'd1;
					end
				end
				S_RREAD: begin
					if (i_q < scnt_q[sx]) begin
						st_q <= S_RWAIT;
					end else begin
						st_q <= S_RFLUSH;
					end
				end
				S_RWAIT: begin
					// The new span goes in ahead of the first stored span that starts after it.
					if (!placed_q && rd_q.start > x_q) begin
						placed_q <= 1'b1;
					end else begin
						i_q <= i_q + 5'd1;
						st_q <= S_RREAD;
					end
				end
				S_RFLUSH: begin
					if (m_q >= 5'(MAX_SPANS)) begin
						done <= 1'b1;
						status <= ST_FULL;
						st_q <= S_IDLE;
					end else begin
						m_q <= m_q + 5'd1;
						i_q <= '0;
						st_q <= S_RWB;
					end
				end
				S_RWB: begin
					if (i_q == m_q) begin
						done <= 1'b1;
						status <= ST_DONE;
						st_q <= S_IDLE;
					end else begin
						i_q <= i_q + 5'd1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: dv/tb.sv
// Self-checking bench for the shelf atlas region allocator core.
// Depends on sara_pkg and shelf_atlas_region_allocator_core; predicts each result in SV.
module tb;
	import sara_pkg::*;

	typedef struct packed {
		logic [1:0]  act;
		logic [12:0] w;
		logic [12:0] h;
		logic [11:0] x;
		logic [11:0] y;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [11:0] px;
		logic [11:0] py;
		logic [12:0] pw;
		logic [12:0] ph;
	} grant_t;

	localparam int WATCHDOG = 20000;
	localparam logic [1:0] ACT_UNDEF = 2'd3;
	localparam logic [1:0] CFG_UNDEF = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  action = '0;
	logic [12:0] item_w = '0;
	logic [12:0] item_h = '0;
	logic [11:0] slot_x = '0;
	logic [11:0] slot_y = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [12:0] cfg_wdata = '0;
	logic        done;
	logic [1:0]  status;
	logic [11:0] place_x, place_y;
	logic [12:0] place_w, place_h;

	shelf_atlas_region_allocator_core dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow allocator state.
	int unsigned atl_w, atl_h, n_shelves;
	int unsigned sh_top [MAX_SHELVES];
	int unsigned sh_hgt [MAX_SHELVES];
	int unsigned sh_fill [MAX_SHELVES];
	int unsigned sh_nspan [MAX_SHELVES];
	int unsigned sp_start [MAX_SHELVES][MAX_SPANS];
	int unsigned sp_len [MAX_SHELVES][MAX_SPANS];

	cmd_t   pending_cmds[$];
	grant_t expected_grants[$];
	int     mismatches = 0;
	int     idle_cycles = 0;
	bit     sender_hold = 1'b0;
	bit     no_gaps = 1'b0;
	bit     stim_done = 1'b0;

	function automatic grant_t reject();
		grant_t g;
		g = '0;
		g.st = ST_REJECT;
		return g;
	endfunction

	function automatic grant_t predict_alloc(int unsigned w, int unsigned h);
		int unsigned aw, ah, x, y;
		grant_t g;
		aw = (atl_w > SIDE_MAX) ? SIDE_MAX : atl_w;
		ah = (atl_h > SIDE_MAX) ? SIDE_MAX : atl_h;
		g = '0;
		if (w == 0 || h == 0 || w > aw || h > ah) return reject();
		for (int s = 0; s < n_shelves; s++) begin
			if (sh_hgt[s] != h) continue;
			for (int i = 0; i < sh_nspan[s]; i++) begin
				if (sp_len[s][i] < w) continue;
				x = sp_start[s][i];
				if (sp_len[s][i] > w) begin
					sp_start[s][i] += w;
					sp_len[s][i] -= w;
				end else begin
					for (int k = i + 1; k < sh_nspan[s]; k++) begin
						sp_start[s][k-1] = sp_start[s][k];
						sp_len[s][k-1] = sp_len[s][k];
					end
					sh_nspan[s]--;
				end
				g.px = 12'(x); g.py = 12'(sh_top[s]); g.pw = 13'(w); g.ph = 13'(h);
				return g;
			end
			if (sh_fill[s] + w <= aw) begin
				g.px = 12'(sh_fill[s]); g.py = 12'(sh_top[s]);
				g.pw = 13'(w); g.ph = 13'(h);
				sh_fill[s] += w;
				return g;
			end
		end
		y = (n_shelves > 0) ? sh_top[n_shelves-1] + sh_hgt[n_shelves-1] : 0;
		if (y + h > ah || n_shelves >= MAX_SHELVES) return reject();
		sh_top[n_shelves] = y;
		sh_hgt[n_shelves] = h;
		sh_fill[n_shelves] = w;
		sh_nspan[n_shelves] = 0;
		n_shelves++;
		g.py = 12'(y); g.pw = 13'(w); g.ph = 13'(h);
		return g;
	endfunction

	function automatic grant_t predict_release(int unsigned x, int unsigned y,
			int unsigned w, int unsigned h);
		int unsigned ts [MAX_SPANS+1];
		int unsigned tl [MAX_SPANS+1];
		int unsigned len, n, m, s;
		bit placed;
		grant_t g;
		g = '0;
		placed = 0;
		if (w == 0 || h == 0 || x >= SIDE_MAX) return reject();
		len = (w > SIDE_MAX - x) ? SIDE_MAX - x : w;
		s = n_shelves;
		for (int i = 0; i < n_shelves; i++)
			if (s == n_shelves && sh_top[i] == y && sh_hgt[i] == h) s = i;
		if (s >= n_shelves) return reject();
		n = 0;
		for (int i = 0; i < sh_nspan[s]; i++) begin
			if (!placed && sp_start[s][i] > x) begin
				ts[n] = x; tl[n] = len; n++; placed = 1;
			end
			ts[n] = sp_start[s][i]; tl[n] = sp_len[s][i]; n++;
		end
		if (!placed) begin
			ts[n] = x; tl[n] = len; n++;
		end
		m = 1;
		for (int i = 1; i < n; i++) begin
			if (ts[m-1] + tl[m-1] == ts[i]) tl[m-1] += tl[i];
			else begin
				ts[m] = ts[i]; tl[m] = tl[i]; m++;
			end
		end
		if (m > MAX_SPANS) begin
			g.st = ST_FULL;
			return g;
		end
		for (int i = 0; i < m; i++) begin
			sp_start[s][i] = ts[i];
			sp_len[s][i] = tl[i];
		end
		sh_nspan[s] = m;
		return g;
	endfunction

	function automatic grant_t predict_grant(cmd_t c);
		case (c.act)
			ACT_ALLOC: return predict_alloc(c.w, c.h);
			ACT_RELEASE: return predict_release(c.x, c.y, c.w, c.h);
			ACT_CLEAR: begin
				n_shelves = 0;
				return '0;
			end
			default: return reject();
		endcase
	endfunction

	// Driver: one beat per accepted command, random gaps unless disabled.
	always @(posedge clk) begin
		cmd_t taken;
		if (arst_n) begin
			if (start && !busy) begin
				taken = pending_cmds.pop_front();
				expected_grants.insert(expected_grants.size(), predict_grant(taken));
			end
			if (!(start && busy)) begin
				if (pending_cmds.size() > 0 && !sender_hold
						&& (no_gaps || $urandom_range(99) >= 31)) begin
					start <= 1'b1;
					action <= pending_cmds[0].act;
					item_w <= pending_cmds[0].w;
					item_h <= pending_cmds[0].h;
					slot_x <= pending_cmds[0].x;
					slot_y <= pending_cmds[0].y;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		grant_t got, exp_g;
		if (arst_n) begin
			if (done) begin
				got = {status, place_x, place_y, place_w, place_h};
				if (expected_grants.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", got);
				end else begin
					exp_g = expected_grants.pop_front();
					if (got !== exp_g) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp st=%0d x=%0d y=%0d w=%0d h=%0d,",
								" got st=%0d x=%0d y=%0d w=%0d h=%0d"},
								exp_g.st, exp_g.px, exp_g.py, exp_g.pw, exp_g.ph,
								got.st, got.px, got.py, got.pw, got.ph);
					end
				end
			end
			if (done || (start && !busy)) idle_cycles = 0;
			else if (!stim_done || expected_grants.size() > 0) idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic cmd_t mk(logic [1:0] a, int unsigned w, int unsigned h,
			int unsigned x, int unsigned y);
		cmd_t c;
		c.act = a; c.w = 13'(w); c.h = 13'(h); c.x = 12'(x); c.y = 12'(y);
		return c;
	endfunction

	function automatic void add_cmd(cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	// Waits until every command was taken and every result came back.
	task automatic drain();
		while (pending_cmds.size() > 0 || start || expected_grants.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, int unsigned v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= 13'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_WIDTH) atl_w = v[12:0];
		else if (idx == CFG_HEIGHT) atl_h = v[12:0];
	endtask

	// Random command mix biased toward shelf reuse, with frees at random positions.
	task automatic queue_random(int count);
		int unsigned hs [4];
		int unsigned r, w, h;
		hs = '{4, 8, 16, $urandom_range(1, 64)};
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			h = hs[$urandom_range(3)];
			w = ($urandom_range(9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 96);
			if (r < 55) add_cmd(mk(ACT_ALLOC, w, h, 0, 0));
			else if (r < 85)
				add_cmd(mk(ACT_RELEASE, $urandom_range(1, 64),
					h, $urandom_range(0, 400), 4 * $urandom_range(0, 40)));
			else if (r < 88) add_cmd(mk(ACT_CLEAR, 0, 0, 0, 0));
			else if (r < 90) add_cmd(mk(ACT_UNDEF, w, h, 0, 0));
			else
				add_cmd(mk(2'($urandom_range(3)), $urandom_range(0, 8191),
					$urandom_range(0, 8191), $urandom_range(0, 4095),
					$urandom_range(0, 4095)));
		end
	endtask

	initial begin
		atl_w = 1024;
		atl_h = 1024;
		n_shelves = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		write_cfg(CFG_WIDTH, 64);
		write_cfg(CFG_HEIGHT, 4096);
		add_cmd(mk(ACT_ALLOC, 0, 8, 0, 0));
		add_cmd(mk(ACT_ALLOC, 8, 0, 0, 0));
		add_cmd(mk(ACT_ALLOC, 65, 8, 0, 0));
		add_cmd(mk(ACT_ALLOC, 16, 8, 0, 0));
		add_cmd(mk(ACT_ALLOC, 16, 8, 0, 0));
		add_cmd(mk(ACT_ALLOC, 64, 4, 0, 0));
		add_cmd(mk(ACT_RELEASE, 16, 8, 0, 0));
		add_cmd(mk(ACT_RELEASE, 16, 8, 16, 0));
		add_cmd(mk(ACT_RELEASE, 16, 8, 8, 0));
		add_cmd(mk(ACT_RELEASE, 16, 9, 0, 0));
		add_cmd(mk(ACT_RELEASE, 8191, 4, 4095, 8));
		add_cmd(mk(ACT_ALLOC, 10, 8, 0, 0));
		add_cmd(mk(ACT_ALLOC, 32, 8, 0, 0));
		add_cmd(mk(ACT_UNDEF, 8191, 8191, 4095, 4095));
		add_cmd(mk(ACT_RELEASE, 0, 8, 0, 0));
		// Fragment one shelf past its span limit.
		for (int i = 0; i < 17; i++)
			add_cmd(mk(ACT_RELEASE, 1, 4, 100 + 2 * i, 8));
		drain();
		add_cmd(mk(ACT_CLEAR, 0, 0, 0, 0));
		drain();
		write_cfg(CFG_WIDTH, 4096);
		write_cfg(CFG_HEIGHT, 40);
		for (int i = 0; i < 40; i++) add_cmd(mk(ACT_ALLOC, 4096, 1, 0, 0));
		add_cmd(mk(ACT_ALLOC, 4096, 4096, 0, 0));
		drain();
		write_cfg(CFG_WIDTH, 0);
		write_cfg(CFG_UNDEF, 5);
		add_cmd(mk(ACT_ALLOC, 1, 1, 0, 0));
		add_cmd(mk(ACT_CLEAR, 0, 0, 0, 0));
		drain();
		write_cfg(CFG_WIDTH, 8191);
		write_cfg(CFG_HEIGHT, 0);
		add_cmd(mk(ACT_ALLOC, 1, 1, 0, 0));
		drain();

		// Random phases across atlas sizes; one runs without gaps.
		for (int ph = 0; ph < 4; ph++) begin
			write_cfg(CFG_WIDTH, (ph == 3) ? 8191 : $urandom_range(64, 1024));
			write_cfg(CFG_HEIGHT, (ph == 2) ? 4096 : $urandom_range(32, 512));
			no_gaps = (ph == 1);
			queue_random(40);
			// Sender holds until all outstanding results have come.
			while (pending_cmds.size() > 20) @(posedge clk);
			sender_hold = 1'b1;
			while (start || expected_grants.size() > 0) @(posedge clk);
			sender_hold = 1'b0;
			queue_random(40);
			drain();
		end
		no_gaps = 1'b0;
		stim_done = 1'b1;
		drain();
		if (mismatches == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
